@@ sv/mbe_pkg.sv @@
package mbe_pkg;

    // pixel coordinate and register field widths
    localparam int COORD_W = 12;
    localparam int WIDTH_W = 13;
    localparam int ITER_W  = 16;
    localparam int INDEX_W = 24;
    localparam int DATA_W  = 32;

    // shared multiplier: 33-bit signed operands, so that 32-bit signed and
    // zero-extended unsigned operands share one unit
    localparam int MUL_W  = DATA_W + 1;
    localparam int PROD_W = 2 * DATA_W;

    typedef logic signed [MUL_W-1:0]  t_mul_opd;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [DATA_W-1:0] t_q;

    typedef struct packed {
        t_mul_opd a;
        t_mul_opd b;
    } t_mul_req;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ORIGIN_RE = 3'd0;
    localparam t_cfg_idx CFG_ORIGIN_IM = 3'd1;
    localparam t_cfg_idx CFG_STEP_RE   = 3'd2;
    localparam t_cfg_idx CFG_STEP_IM   = 3'd3;
    localparam t_cfg_idx CFG_WIDTH     = 3'd4;
    localparam t_cfg_idx CFG_MAX_ITER  = 3'd5;

    localparam logic [WIDTH_W-1:0] WIDTH_RST    = 13'd4096;
    localparam logic [ITER_W-1:0]  MAX_ITER_RST = 16'd256;

endpackage

@@ sv/mbe_mul.sv @@
module mbe_mul (
    input  logic              i_clk,
    input  mbe_pkg::t_mul_req i_req,
    output mbe_pkg::t_prod    o_prod
);
    import mbe_pkg::*;

    logic signed [2*MUL_W-1:0] w_full;
    t_prod                     r_prod;

    assign w_full = i_req.a * i_req.b;

    // operands in use never need more than 64 product bits
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_full[PROD_W-1:0]);
    end

    assign o_prod = r_prod;

endmodule

@@ sv/mandelbrot_escape_iteration.sv @@
// Escape-time evaluator, one pixel word at a time on one registered 33x33 multiplier.
// Steps: set-up in S_CRE, S_CIM, S_IDX and S_PIX, then per iteration zr^2, zi^2, zr*zi and
// update, then S_OUT loads the output register and o_valid rises; S_OUT waits while a held
// result is stalled. The next word can be taken in the cycle that o_valid rises; a waiting
// result does not block the next word.
// Reset: synchronous, active low; clears the sequencer and output valid, loads defaults.
module mandelbrot_escape_iteration #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 26
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [mbe_pkg::COORD_W-1:0]    i_pixel_col,
    input  logic [mbe_pkg::COORD_W-1:0]    i_pixel_row,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [mbe_pkg::ITER_W-1:0]     o_iteration_count,
    output logic [mbe_pkg::INDEX_W-1:0]    o_pixel_index,
    input  logic                           i_cfg_wr_en,
    input  mbe_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [mbe_pkg::DATA_W-1:0]     i_cfg_data
);
    import mbe_pkg::*;

    localparam t_q    ORIGIN_RE_RST = -(32'sd2 <<< FRAC_BITS);
    localparam t_q    ORIGIN_IM_RST = -(32'sd1 <<< FRAC_BITS);
    localparam t_q    STEP_RE_RST   = 32'sd3 <<< (FRAC_BITS - 12);
    localparam t_q    STEP_IM_RST   = 32'sd1 <<< (FRAC_BITS - 11);
    localparam logic [PROD_W-1:0] LIMIT4 = 64'd4 << (2 * FRAC_BITS);
    localparam t_prod SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam t_prod SAT_LO = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [3:0] {
        S_IDLE, S_CRE, S_CIM, S_IDX, S_PIX, S_RR, S_II, S_RI, S_UPD, S_OUT
    } t_state;

    function automatic t_q sat32(input t_prod v);
        t_q res;
        if (v > SAT_HI) begin
            res = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

    t_state r_state;

    t_q                 r_origin_re, r_origin_im, r_step_re, r_step_im;
    logic [WIDTH_W-1:0] r_image_width;
    logic [ITER_W-1:0]  r_max_iter;

    logic [COORD_W-1:0] r_col, r_row;
    t_q                 r_c_re, r_c_im, r_z_re, r_z_im;
    t_prod              r_rr, r_diff;
    logic               r_esc;
    logic [ITER_W-1:0]  r_iter;
    logic [INDEX_W-1:0] r_index;

    logic               r_out_valid;
    logic [ITER_W-1:0]  r_out_count;
    logic [INDEX_W-1:0] r_out_index;

    t_mul_req           w_req;
    t_prod              w_prod;
    logic [31:0]        w_width_ext;
    logic [WIDTH_W-1:0] w_width;
    logic [ITER_W-1:0]  w_iter_inc;
    logic               w_accept;
    logic               w_out_free;
    t_prod              w_sum_re, w_sum_im;

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_iter_inc = r_iter + 16'd1;

    // width above MAX_DIM is used as MAX_DIM; result never exceeds the register value
    assign w_width_ext = 32'(r_image_width);
    assign w_width     = (w_width_ext > 32'(MAX_DIM)) ? WIDTH_W'(MAX_DIM) : r_image_width;

    always_comb begin
        w_req.a = {r_z_re[DATA_W-1], r_z_re};
        w_req.b = {r_z_im[DATA_W-1], r_z_im};
        case (r_state)
            S_CRE: begin
                w_req.a = $signed({{(MUL_W-COORD_W){1'b0}}, r_col});
                w_req.b = {r_step_re[DATA_W-1], r_step_re};
            end
            S_CIM: begin
                w_req.a = $signed({{(MUL_W-COORD_W){1'b0}}, r_row});
                w_req.b = {r_step_im[DATA_W-1], r_step_im};
            end
            S_IDX: begin
                w_req.a = $signed({{(MUL_W-COORD_W){1'b0}}, r_row});
                w_req.b = $signed({{(MUL_W-WIDTH_W){1'b0}}, w_width});
            end
            S_RR: begin
                w_req.a = {r_z_re[DATA_W-1], r_z_re};
                w_req.b = {r_z_re[DATA_W-1], r_z_re};
            end
            S_II: begin
                w_req.a = {r_z_im[DATA_W-1], r_z_im};
                w_req.b = {r_z_im[DATA_W-1], r_z_im};
            end
            default: begin
            end
        endcase
    end

    mbe_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    // new z: floor shifts; the cross product shifts one less, giving 2*zr*zi
    assign w_sum_re = $signed({{DATA_W{r_c_re[DATA_W-1]}}, r_c_re}) + (r_diff >>> FRAC_BITS);
    assign w_sum_im = $signed({{DATA_W{r_c_im[DATA_W-1]}}, r_c_im})
                    + (w_prod >>> (FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_origin_re   <= ORIGIN_RE_RST;
            r_origin_im   <= ORIGIN_IM_RST;
            r_step_re     <= STEP_RE_RST;
            r_step_im     <= STEP_IM_RST;
            r_image_width <= WIDTH_RST;
            r_max_iter    <= MAX_ITER_RST;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    CFG_ORIGIN_RE: r_origin_re   <= $signed(i_cfg_data);
                    CFG_ORIGIN_IM: r_origin_im   <= $signed(i_cfg_data);
                    CFG_STEP_RE:   r_step_re     <= $signed(i_cfg_data);
                    CFG_STEP_IM:   r_step_im     <= $signed(i_cfg_data);
                    CFG_WIDTH:     r_image_width <= i_cfg_data[WIDTH_W-1:0];
                    CFG_MAX_ITER:  r_max_iter    <= i_cfg_data[ITER_W-1:0];
                    default: begin
                    end
                endcase
            end

            // in S_OUT the output register is reloaded instead
            if (r_out_valid && !i_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            // a product issued in one state is in w_prod in the next
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_col   <= i_pixel_col;
                        r_row   <= i_pixel_row;
                        r_state <= S_CRE;
                    end
                end
                S_CRE: begin
                    r_state <= S_CIM;
                end
                S_CIM: begin
                    r_c_re  <= sat32($signed({{DATA_W{r_origin_re[DATA_W-1]}}, r_origin_re})
                                     + w_prod);
                    r_z_re  <= sat32($signed({{DATA_W{r_origin_re[DATA_W-1]}}, r_origin_re})
                                     + w_prod);
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    r_c_im  <= sat32($signed({{DATA_W{r_origin_im[DATA_W-1]}}, r_origin_im})
                                     + w_prod);
                    r_z_im  <= sat32($signed({{DATA_W{r_origin_im[DATA_W-1]}}, r_origin_im})
                                     + w_prod);
                    r_state <= S_PIX;
                end
                S_PIX: begin
                    r_index <= w_prod[INDEX_W-1:0] + INDEX_W'(r_col);
                    r_iter  <= '0;
                    r_state <= (r_max_iter == '0) ? S_OUT : S_RR;
                end
                S_RR: begin
                    r_state <= S_II;
                end
                S_II: begin
                    r_rr    <= w_prod;
                    r_state <= S_RI;
                end
                S_RI: begin
                    r_esc   <= ($unsigned(r_rr) + $unsigned(w_prod)) > LIMIT4;
                    r_diff  <= r_rr - w_prod;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_esc) begin
                        r_state <= S_OUT;
                    end else begin
                        r_z_re  <= sat32(w_sum_re);
                        r_z_im  <= sat32(w_sum_im);
                        r_iter  <= w_iter_inc;
                        r_state <= (w_iter_inc == r_max_iter) ? S_OUT : S_RR;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_count <= r_iter;
                        r_out_index <= r_index;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_pixel_index     = r_out_index;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CRE))
        else $error("accepted word did not start set-up");

    a_iter_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RR) |=> (r_state == S_II) ##1 (r_state == S_RI) ##1 (r_state == S_UPD))
        else $error("iteration sequence broken");

    a_escape_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_esc) |=> (r_state == S_OUT) && $stable(r_z_re) && $stable(r_iter))
        else $error("escaped point kept iterating");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result word not loaded");

endmodule
